// ----- design/ts_pkg.sv -----
// ----------------------------------------------------------------------------
// Token scanner package
// Token kind codes that the scanner and its checker share, and the byte
// class functions of the scanner.
// ----------------------------------------------------------------------------
package ts_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [KindW-1:0] kind_t;

  localparam kind_t KIND_IDENT = 3'd0;
  localparam kind_t KIND_INT   = 3'd1;
  localparam kind_t KIND_STR   = 3'd2;
  localparam kind_t KIND_OP    = 3'd3;
  localparam kind_t KIND_PUNCT = 3'd4;
  localparam kind_t KIND_ERR   = 3'd5;

  localparam byte_t CH_NL    = 8'h0A;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_DQUOTE = 8'h22;
  localparam byte_t CH_SLASH = 8'h2F;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_USCORE = 8'h5F;
  localparam byte_t CH_LOW_T = 8'h74;
  localparam byte_t CH_LOW_N = 8'h6E;

  function automatic logic is_letter(byte_t c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(byte_t c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(byte_t c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL;
  endfunction

  // Operator symbols: + - * < > & . @ / : = ~ | $ ! # % ^ _ [ ] { } ' ?
  function automatic logic is_op(byte_t c);
    logic r;
    unique case (c)
      8'h2B, 8'h2D, 8'h2A, 8'h3C, 8'h3E, 8'h26, 8'h2E, 8'h40, 8'h2F,
      8'h3A, 8'h3D, 8'h7E, 8'h7C, 8'h24, 8'h21, 8'h23, 8'h25, 8'h5E,
      8'h5F, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h27, 8'h3F: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Punctuation: ( ) ; ,
  function automatic logic is_punct(byte_t c);
    return c == 8'h28 || c == 8'h29 || c == 8'h3B || c == 8'h2C;
  endfunction

  function automatic logic str_allowed(byte_t c);
    return c == CH_SPACE || is_digit(c) || is_letter(c) || is_op(c) || is_punct(c);
  endfunction

  function automatic logic esc_allowed(byte_t c);
    return c == CH_LOW_T || c == CH_LOW_N || c == CH_BSLASH || c == CH_DQUOTE;
  endfunction

endpackage

// ----- design/token_scanner.sv -----
// ----------------------------------------------------------------------------
// Token scanner
// Tags the bytes of identifiers, integers, strings, operators and
// punctuation in a text stream, one byte per item, each held back one item.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   input   | in        | in_valid_i / in_ready_o | char_in_i
//   result  | out       | out_valid_o/ out_ready_i| token_byte_o, token_kind_o,
//           |           |                         | token_first_o, token_last_o
//
// One item is taken per cycle; the class decode and the mode update are
// combinational, between the scan state and the result register.
// A result shows in the cycle after the item that caused it is accepted.
// The input is stalled only while the result register is full and not taken.
// Reset puts the scanner in its idle mode with nothing held; an escape error
// halts it until the next reset.

module token_scanner (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  ts_pkg::byte_t           char_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output ts_pkg::byte_t           token_byte_o,
  output ts_pkg::kind_t           token_kind_o,
  output logic                    token_first_o,
  output logic                    token_last_o
);
  import ts_pkg::*;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_INT     = 3'd2;
  localparam logic [2:0] MODE_STR     = 3'd3;
  localparam logic [2:0] MODE_ESC     = 3'd4;
  localparam logic [2:0] MODE_OP      = 3'd5;
  localparam logic [2:0] MODE_COMMENT = 3'd6;
  localparam logic [2:0] MODE_HALT    = 3'd7;

  logic [2:0] mode_q, mode_d;
  logic       held_valid_q, held_valid_d;
  byte_t      held_byte_q, held_byte_d;
  kind_t      held_kind_q, held_kind_d;
  logic       held_first_q, held_first_d;

  logic       out_valid_q;
  byte_t      out_byte_q;
  kind_t      out_kind_q;
  logic       out_first_q, out_last_q;

  logic       emit;
  byte_t      e_byte;
  kind_t      e_kind;
  logic       e_first, e_last;
  logic       in_fire;
  logic       cont;
  byte_t      c;

  assign c          = char_in_i;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    mode_d       = mode_q;
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    held_kind_d  = held_kind_q;
    held_first_d = held_first_q;
    emit         = 1'b0;
    e_byte       = held_byte_q;
    e_kind       = held_kind_q;
    e_first      = held_first_q;
    e_last       = 1'b0;
    cont         = 1'b0;

    unique case (mode_q)
      MODE_HALT: begin
      end
      MODE_COMMENT: begin
        if (c == CH_NL) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_STR: begin
        if (c == CH_BSLASH || c == CH_DQUOTE || str_allowed(c)) begin
          emit         = held_valid_q;
          held_valid_d = 1'b1;
          held_byte_d  = c;
          held_kind_d  = KIND_STR;
          held_first_d = 1'b0;
          if (c == CH_BSLASH) begin
            mode_d = MODE_ESC;
          end else if (c == CH_DQUOTE) begin
            mode_d = MODE_IDLE;
          end
        end
      end
      MODE_ESC: begin
        if (esc_allowed(c)) begin
          emit         = held_valid_q;
          held_valid_d = 1'b1;
          held_byte_d  = c;
          held_kind_d  = KIND_STR;
          held_first_d = 1'b0;
          mode_d       = MODE_STR;
        end else begin
          // The held backslash is dropped and the offending byte reported.
          held_valid_d = 1'b0;
          mode_d       = MODE_HALT;
          emit         = 1'b1;
          e_byte       = c;
          e_kind       = KIND_ERR;
          e_first      = 1'b1;
          e_last       = 1'b1;
        end
      end
      default: begin
        cont = (mode_q == MODE_IDENT && (is_letter(c) || is_digit(c) || c == CH_USCORE)) ||
               (mode_q == MODE_INT && is_digit(c)) ||
               (mode_q == MODE_OP && is_op(c));
        if (mode_q == MODE_OP && held_valid_q && held_first_q &&
            held_byte_q == CH_SLASH && c == CH_SLASH) begin
          held_valid_d = 1'b0;
          mode_d       = MODE_COMMENT;
        end else if (cont && held_valid_q) begin
          emit         = 1'b1;
          held_byte_d  = c;
          held_first_d = 1'b0;
        end else begin
          // The byte does not continue the token: close it and start anew.
          emit         = held_valid_q;
          e_last       = 1'b1;
          held_valid_d = 1'b0;
          held_byte_d  = c;
          held_first_d = 1'b1;
          mode_d       = MODE_IDLE;
          if (is_letter(c)) begin
            held_valid_d = 1'b1;
            held_kind_d  = KIND_IDENT;
            mode_d       = MODE_IDENT;
          end else if (is_digit(c)) begin
            held_valid_d = 1'b1;
            held_kind_d  = KIND_INT;
            mode_d       = MODE_INT;
          end else if (c == CH_DQUOTE) begin
            held_valid_d = 1'b1;
            held_kind_d  = KIND_STR;
            mode_d       = MODE_STR;
          end else if (is_space(c)) begin
            mode_d = MODE_IDLE;
          end else if (is_op(c)) begin
            held_valid_d = 1'b1;
            held_kind_d  = KIND_OP;
            mode_d       = MODE_OP;
          end else if (is_punct(c)) begin
            held_valid_d = 1'b1;
            held_kind_d  = KIND_PUNCT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      held_valid_q <= 1'b0;
    end else if (in_fire) begin
      mode_q       <= mode_d;
      held_valid_q <= held_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      held_byte_q  <= held_byte_d;
      held_kind_q  <= held_kind_d;
      held_first_q <= held_first_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_byte_q  <= e_byte;
      out_kind_q  <= e_kind;
      out_first_q <= e_first;
      out_last_q  <= e_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_byte_o  = out_byte_q;
  assign token_kind_o  = out_kind_q;
  assign token_first_o = out_first_q;
  assign token_last_o  = out_last_q;

endmodule

// ----- design/ts_checker.sv -----
// ----------------------------------------------------------------------------
// Token scanner checker
// Port-level properties of the token scanner, bound to its top level.
// ----------------------------------------------------------------------------
module ts_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input ts_pkg::byte_t char_in_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ts_pkg::byte_t token_byte_o,
  input ts_pkg::kind_t token_kind_o,
  input logic          token_first_o,
  input logic          token_last_o
);
  import ts_pkg::*;

  // A result that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_byte_o) &&
    $stable(token_kind_o) && $stable(token_first_o) && $stable(token_last_o))
    else $error("result item changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= KIND_ERR)
    else $error("token kind out of range");

  // Error and punctuation items are always single-byte tokens.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == KIND_ERR || token_kind_o == KIND_PUNCT)
    |-> token_first_o && token_last_o)
    else $error("single-byte token not marked first and last");

  // Once an escape error has gone out, the scanner stays silent.
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && token_kind_o == KIND_ERR |=> !out_valid_o)
    else $error("result after escape error");

endmodule

bind token_scanner ts_checker u_ts_checker (.*);

// ----- sim/token_scanner_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token scanner checker
// Watches both channels of the scanner, predicts the tagged token bytes from
// every accepted text byte and compares each result item with the oldest
// prediction. It reports the number of failures and of outstanding items.
// ----------------------------------------------------------------------------
module token_scanner_chk (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  ts_pkg::byte_t char_in_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  ts_pkg::byte_t token_byte_i,
  input  ts_pkg::kind_t token_kind_i,
  input  logic          token_first_i,
  input  logic          token_last_i,
  output int unsigned   err_cnt_o,
  output int unsigned   owed_cnt_o
);
  import ts_pkg::*;

  localparam string OpSyms = "+-*<>&.@/:=~|$!#%^_[]{}'?";

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_INT, MODE_STR, MODE_ESC, MODE_OP, MODE_COMMENT, MODE_HALT
  } scan_mode_e;

  typedef struct packed {
    byte_t b;
    kind_t k;
    logic  first;
    logic  last;
  } token_t;

  scan_mode_e mode;
  logic       held_vld;
  byte_t      held_b;
  kind_t      held_k;
  logic       held_f;
  token_t     token_q[$];
  token_t     want;

  function automatic logic alpha(byte_t c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic numeral(byte_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic opsym(byte_t c);
    for (int i = 0; i < OpSyms.len(); i++) begin
      if (OpSyms[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic punc(byte_t c);
    return c == "(" || c == ")" || c == ";" || c == ",";
  endfunction

  // Appends one expected item at the tail of the queue.
  task automatic queue_token(input token_t t);
    token_q.insert(token_q.size(), t);
  endtask

  task automatic flush_held(input logic last);
    if (held_vld) begin
      queue_token(token_t'{b: held_b, k: held_k, first: held_f, last: last});
      held_vld = 1'b0;
    end
  endtask

  task automatic hold_byte(input byte_t c, input kind_t k, input logic first);
    held_vld = 1'b1;
    held_b   = c;
    held_k   = k;
    held_f   = first;
  endtask

  task automatic scan_byte(input byte_t c);
    logic grows;
    case (mode)
      MODE_HALT: ;
      MODE_COMMENT: begin
        if (c == CH_NL) mode = MODE_IDLE;
      end
      MODE_STR: begin
        if (c == CH_BSLASH || c == CH_DQUOTE || c == CH_SPACE || alpha(c) || numeral(c) ||
            opsym(c) || punc(c)) begin
          flush_held(1'b0);
          hold_byte(c, KIND_STR, 1'b0);
          if (c == CH_BSLASH) mode = MODE_ESC;
          else if (c == CH_DQUOTE) mode = MODE_IDLE;
        end
      end
      MODE_ESC: begin
        if (c == CH_LOW_T || c == CH_LOW_N || c == CH_BSLASH || c == CH_DQUOTE) begin
          flush_held(1'b0);
          hold_byte(c, KIND_STR, 1'b0);
          mode = MODE_STR;
        end else begin
          // The open string is abandoned and only the error item goes out.
          held_vld = 1'b0;
          mode     = MODE_HALT;
          queue_token(token_t'{b: c, k: KIND_ERR, first: 1'b1, last: 1'b1});
        end
      end
      default: begin
        if (mode == MODE_OP && held_vld && held_f && held_b == CH_SLASH && c == CH_SLASH) begin
          held_vld = 1'b0;
          mode     = MODE_COMMENT;
        end else begin
          grows = (mode == MODE_IDENT && (alpha(c) || numeral(c) || c == CH_USCORE)) ||
                  (mode == MODE_INT && numeral(c)) ||
                  (mode == MODE_OP && opsym(c));
          if (grows && held_vld) begin
            flush_held(1'b0);
            hold_byte(c, held_k, 1'b0);
          end else begin
            flush_held(1'b1);
            mode = MODE_IDLE;
            if (alpha(c)) begin
              hold_byte(c, KIND_IDENT, 1'b1);
              mode = MODE_IDENT;
            end else if (numeral(c)) begin
              hold_byte(c, KIND_INT, 1'b1);
              mode = MODE_INT;
            end else if (c == CH_DQUOTE) begin
              hold_byte(c, KIND_STR, 1'b1);
              mode = MODE_STR;
            end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
              mode = MODE_IDLE;
            end else if (opsym(c)) begin
              hold_byte(c, KIND_OP, 1'b1);
              mode = MODE_OP;
            end else if (punc(c)) begin
              hold_byte(c, KIND_PUNCT, 1'b1);
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode       = MODE_IDLE;
      held_vld   = 1'b0;
      held_b     = '0;
      held_k     = '0;
      held_f     = 1'b0;
      token_q.delete();
      err_cnt_o  = 0;
      owed_cnt_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) scan_byte(char_in_i);
      if (out_valid_i && out_ready_i) begin
        if (token_q.size() == 0) begin
          $error("token_byte: no item expected, got %02h", token_byte_i);
          err_cnt_o++;
        end else begin
          want = token_q.pop_front();
          if (token_byte_i !== want.b) begin
            $error("token_byte: expected %02h, got %02h", want.b, token_byte_i);
            err_cnt_o++;
          end
          if (token_kind_i !== want.k) begin
            $error("token_kind: expected %0d, got %0d", want.k, token_kind_i);
            err_cnt_o++;
          end
          if (token_first_i !== want.first) begin
            $error("token_first: expected %0b, got %0b", want.first, token_first_i);
            err_cnt_o++;
          end
          if (token_last_i !== want.last) begin
            $error("token_last: expected %0b, got %0b", want.last, token_last_i);
            err_cnt_o++;
          end
        end
      end
      owed_cnt_o = token_q.size();
    end
  end

endmodule

// ----- sim/token_scanner_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token scanner testbench
// Feeds a directed text, then randomly built tokens, strings, comments and
// noise through the scanner with random gaps on both sides, one long
// result stall, and a bad escape at the very end. The checker beside the
// scanner predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module token_scanner_tb;
  import ts_pkg::*;

  localparam string Letters   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string Digits    = "0123456789";
  localparam string IdentTail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  localparam string OpSyms    = "+-*<>&.@/:=~|$!#%^_[]{}'?";
  localparam string Puncts    = "();,";
  localparam string Blanks    = " \t\n";
  localparam string EscChars  = "tn\\\"";
  localparam string StrChars  =
    " abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+-*<>&.@/:=~|$!#%^_[]{}'?();,";
  localparam int unsigned NumItems = 1050;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  byte_t       char_in = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  byte_t       token_byte;
  kind_t       token_kind;
  logic        token_first;
  logic        token_last;
  int unsigned err_cnt;
  int unsigned owed_cnt;

  int unsigned sent_cnt = 0;
  bit          hold_off_req = 1'b0;
  int unsigned tx_left = 0;
  bit          tx_calm = 1'b0;
  int unsigned rx_left = 0;
  bit          rx_calm = 1'b0;

  always #4 clk = ~clk;

  token_scanner u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .char_in_i    (char_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .token_byte_o (token_byte),
    .token_kind_o (token_kind),
    .token_first_o(token_first),
    .token_last_o (token_last)
  );

  token_scanner_chk u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .char_in_i    (char_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .token_byte_i (token_byte),
    .token_kind_i (token_kind),
    .token_first_i(token_first),
    .token_last_i (token_last),
    .err_cnt_o    (err_cnt),
    .owed_cnt_o   (owed_cnt)
  );

  // Waits come in stretches: some with no gaps at all, some with random gaps.
  function automatic int unsigned draw_wait(inout int unsigned left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(20, 60);
      calm = ($urandom_range(0, 2) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic byte_t pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // A backslash only ever goes out followed by a legal escape character, so
  // the scanner cannot halt before the final part of the run.
  function automatic byte_t noise_byte();
    byte_t c;
    do c = byte_t'($urandom_range(0, 255)); while (c == CH_BSLASH);
    return c;
  endfunction

  task automatic send_byte(input byte_t c);
    int unsigned gap;
    gap = draw_wait(tx_left, tx_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
    if (sent_cnt == 250) hold_off_req = 1'b1;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic rand_token();
    case ($urandom_range(0, 9))
      0, 1: begin
        send_byte(pick(Letters));
        repeat ($urandom_range(0, 5)) send_byte(pick(IdentTail));
      end
      2: repeat ($urandom_range(1, 5)) send_byte(pick(Digits));
      3: repeat ($urandom_range(1, 3)) send_byte(pick(OpSyms));
      4: send_byte(pick(Puncts));
      5: begin
        send_byte(CH_DQUOTE);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 7))
            0: begin
              send_byte(CH_BSLASH);
              send_byte(pick(EscChars));
            end
            1: send_byte(noise_byte());
            default: send_byte(pick(StrChars));
          endcase
        end
        // Now and then the string is left open and swallows what follows.
        if ($urandom_range(0, 15) != 0) send_byte(CH_DQUOTE);
      end
      6: begin
        send_text("//");
        repeat ($urandom_range(0, 4)) send_byte(noise_byte());
        send_byte(CH_NL);
      end
      7: send_byte(noise_byte());
      default: send_byte(pick(Blanks));
    endcase
    if ($urandom_range(0, 1) != 0) send_byte(pick(Blanks));
  endtask

  initial begin
    #2_000_000;
    $display("token_scanner_tb NOT OK");
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_wait(rx_left, rx_calm);
      if (hold_off_req) begin
        // Long hold-off: the result register fills and the input stalls.
        hold_off_req = 1'b0;
        stall = 400;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identifier with underscore and digit, integer, operator run with a
    // later slash, punctuation, string with escapes and a dropped byte,
    // comment, and bytes that are only skipped.
    send_text("x_9 42+//(;\"a\\t\\\\");
    send_byte(8'hFF);
    send_text("\"//");
    send_byte(8'h00);
    send_byte(CH_NL);
    send_byte(CH_TAB);
    send_byte(8'h80);

    while (sent_cnt < NumItems) rand_token();

    // A bad escape, whether or not a string is open now; then the scanner
    // must ignore everything.
    send_text("\n\"\\q\"\\q");
    send_text("ab; 7");
    in_valid <= 1'b0;

    while (owed_cnt != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("token_scanner_tb OK");
    end else begin
      $display("token_scanner_tb NOT OK");
    end
    $finish;
  end

endmodule
